FILE: design/bmpd_pkg.sv
package bmpd_pkg;

  // result status codes
  localparam logic [2:0] ST_PIXEL      = 3'd0;
  localparam logic [2:0] ST_HDR_OK     = 3'd1;
  localparam logic [2:0] ST_BAD_MAGIC  = 3'd2;
  localparam logic [2:0] ST_BAD_PLANES = 3'd3;
  localparam logic [2:0] ST_COMPRESSED = 3'd4;
  localparam logic [2:0] ST_BAD_DEPTH  = 3'd5;
  localparam logic [2:0] ST_NEG_SIZE   = 3'd6;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd7;

  // header byte offsets
  localparam logic [5:0] OFS_MAGIC_LAST = 6'd13;
  localparam logic [5:0] OFS_WIDTH      = 6'd18;
  localparam logic [5:0] OFS_HEIGHT     = 6'd22;
  localparam logic [5:0] OFS_PLANES     = 6'd26;
  localparam logic [5:0] OFS_DEPTH      = 6'd28;
  localparam logic [5:0] OFS_COMPRESS   = 6'd30;
  localparam logic [5:0] OFS_COMP_LAST  = 6'd33;
  localparam logic [5:0] OFS_HDR_LAST   = 6'd53;

  localparam logic [15:0] MAGIC_BM    = 16'h4D42;
  localparam logic [15:0] PIXEL_DEPTH = 16'd24;

  typedef struct packed {
    logic        fire;
    logic [2:0]  code;
    logic        empty;
    logic [12:0] img_w;
    logic [12:0] img_h;
  } hdr_res_t;

  typedef struct packed {
    logic        fire;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last;
  } pix_res_t;

endpackage

FILE: design/bmpd_hdr.sv
module bmpd_hdr #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               start,
  input  logic [7:0]         data,
  output bmpd_pkg::hdr_res_t hdr_res,
  output logic [31:0]        width_word,
  output logic [31:0]        height_word
);
  import bmpd_pkg::*;

  logic [5:0]  header_count;
  logic [15:0] magic_word;
  logic [15:0] planes_word;
  logic [15:0] depth_word;
  logic [31:0] compress_word;

  logic [5:0]  n;
  logic [15:0] magic_next, planes_next, depth_next;
  logic [31:0] width_next, height_next, compress_next;
  logic [1:0]  lane_w, lane_h, lane_c;
  logic [2:0]  code;

  assign n      = start ? 6'd0 : header_count;
  assign lane_w = 2'(n - OFS_WIDTH);
  assign lane_h = 2'(n - OFS_HEIGHT);
  assign lane_c = 2'(n - OFS_COMPRESS);

  always_comb begin
    magic_next    = start ? '0 : magic_word;
    width_next    = start ? '0 : width_word;
    height_next   = start ? '0 : height_word;
    planes_next   = start ? '0 : planes_word;
    depth_next    = start ? '0 : depth_word;
    compress_next = start ? '0 : compress_word;
    if (n <= 6'd1) begin
      magic_next[{n[0], 3'b000} +: 8] = data;
    end else if (n >= OFS_WIDTH && n < OFS_HEIGHT) begin
      width_next[{lane_w, 3'b000} +: 8] = data;
    end else if (n >= OFS_HEIGHT && n < OFS_PLANES) begin
      height_next[{lane_h, 3'b000} +: 8] = data;
    end else if (n >= OFS_PLANES && n < OFS_DEPTH) begin
      planes_next[{n[0], 3'b000} +: 8] = data;
    end else if (n >= OFS_DEPTH && n < OFS_COMPRESS) begin
      depth_next[{n[0], 3'b000} +: 8] = data;
    end else if (n >= OFS_COMPRESS && n <= OFS_COMP_LAST) begin
      compress_next[{lane_c, 3'b000} +: 8] = data;
    end
  end

  // first failing check wins
  always_comb begin
    if (planes_next != 16'd1) begin
      code = ST_BAD_PLANES;
    end else if (compress_next != 32'd0) begin
      code = ST_COMPRESSED;
    end else if (depth_next != PIXEL_DEPTH) begin
      code = ST_BAD_DEPTH;
    end else if (width_next[31] || height_next[31]) begin
      code = ST_NEG_SIZE;
    end else if (width_next > 32'(MAX_DIM) || height_next > 32'(MAX_DIM)) begin
      code = ST_TOO_LARGE;
    end else begin
      code = ST_HDR_OK;
    end
  end

  always_comb begin
    hdr_res       = '0;
    hdr_res.img_w = width_next[12:0];
    hdr_res.img_h = height_next[12:0];
    hdr_res.empty = (width_next == 32'd0) || (height_next == 32'd0);
    if (n == OFS_MAGIC_LAST && magic_next != MAGIC_BM) begin
      hdr_res.fire = step;
      hdr_res.code = ST_BAD_MAGIC;
    end else if (n == OFS_HDR_LAST) begin
      hdr_res.fire = step;
      hdr_res.code = code;
    end else begin
      hdr_res.code = ST_HDR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count <= '0;
    end else if (step) begin
      header_count <= n + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      magic_word    <= magic_next;
      width_word    <= width_next;
      height_word   <= height_next;
      planes_word   <= planes_next;
      depth_word    <= depth_next;
      compress_word <= compress_next;
    end
  end

endmodule

FILE: design/bmpd_pix.sv
module bmpd_pix #(
  parameter int MAX_DIM = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic               clear,
  input  logic [7:0]         data,
  input  logic [31:0]        width_word,
  input  logic [31:0]        height_word,
  output bmpd_pkg::pix_res_t pix_res
);
  import bmpd_pkg::*;

  localparam int CW = $clog2(MAX_DIM + 1);

  logic [CW-1:0] column_count, row_count;
  logic [1:0]    byte_in_pixel, pad_count;
  logic [7:0]    held_blue, held_green;
  logic          row_end, img_end;
  logic [31:0]   col_ext, row_ext;

  assign col_ext = 32'(column_count);
  assign row_ext = 32'(row_count);
  assign row_end = (col_ext + 32'd1) >= width_word;
  assign img_end = (row_ext + 32'd1) >= height_word;

  always_comb begin
    pix_res        = '0;
    pix_res.red    = data;
    pix_res.green  = held_green;
    pix_res.blue   = held_blue;
    pix_res.column = col_ext[11:0];
    pix_res.row    = row_ext[11:0];
    pix_res.last   = row_end && img_end;
    pix_res.fire   = step && pad_count == 2'd0 && byte_in_pixel == 2'd2;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      column_count  <= '0;
      row_count     <= '0;
      byte_in_pixel <= '0;
      pad_count     <= '0;
    end else if (step) begin
      if (pad_count != 2'd0) begin
        pad_count <= pad_count - 2'd1;
      end else if (byte_in_pixel != 2'd2) begin
        byte_in_pixel <= byte_in_pixel + 2'd1;
      end else begin
        byte_in_pixel <= '0;
        if (row_end) begin
          column_count <= '0;
          if (!img_end) begin
            row_count <= row_count + CW'(1);
            pad_count <= width_word[1:0];
          end
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && pad_count == 2'd0) begin
      if (byte_in_pixel == 2'd0) begin
        held_blue <= data;
      end
      if (byte_in_pixel == 2'd1) begin
        held_green <= data;
      end
    end
  end

endmodule

FILE: design/bmp24_stream_decoder.sv
// bmp24_stream_decoder: streaming decoder for uncompressed 24-bit BMP files.
// Input channel (data_valid/data_stall) carries one file byte per beat;
// frame_start marks byte 0 of a file and restarts parsing at that byte.
// Output channel (result_valid/result_stall) carries at most one result beat
// per input beat: a header verdict (status 1 ok, 2..7 first error found) at
// byte 13 (bad magic) or byte 53, then one pixel (status 0) per three bytes
// from byte 54, with column/row and end_of_image on the last pixel.
// Row padding (width mod 4 bytes) is dropped; bytes after an error or after
// the last pixel are ignored until the next frame_start.
// Throughput: one byte per cycle while the receiver does not stall, set by
// a single pass of counter and compare logic between the input register and
// the result register. Each result is computed from the byte in the input
// register and then held in the result register until it is accepted.
// While the receiver stalls, one further byte is held in the input register,
// then data_stall rises. Reset (rst, synchronous) empties both registers and
// leaves the decoder idle, waiting for frame_start.
module bmp24_stream_decoder #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        frame_start,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  status,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [11:0] column,
  output logic [11:0] row,
  output logic        end_of_image,
  output logic [12:0] image_width,
  output logic [12:0] image_height
);
  import bmpd_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_PIXELS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_start;

  logic [1:0] phase, phase_eff, phase_next;
  logic       out_free, adv, go;
  logic       hdr_step, pix_step;
  logic [31:0] width_word, height_word;
  hdr_res_t   hdr_res;
  pix_res_t   pix_res;

  // the result register drains or is empty: the current byte may move on
  assign out_free   = !result_valid || !result_stall;
  assign adv        = !s1_valid || out_free;
  assign data_stall = !adv;
  assign go         = adv && s1_valid;

  // a frame start overrides whatever phase the last frame left
  assign phase_eff = s1_start ? PH_HEADER : phase;
  assign hdr_step  = go && phase_eff == PH_HEADER;
  assign pix_step  = go && phase_eff == PH_PIXELS;

  bmpd_hdr #(.MAX_DIM(MAX_DIM)) u_hdr (
    .clk         (clk),
    .rst         (rst),
    .step        (hdr_step),
    .start       (s1_start),
    .data        (s1_byte),
    .hdr_res     (hdr_res),
    .width_word  (width_word),
    .height_word (height_word)
  );

  bmpd_pix #(.MAX_DIM(MAX_DIM)) u_pix (
    .clk         (clk),
    .rst         (rst),
    .step        (pix_step),
    .clear       (go && s1_start),
    .data        (s1_byte),
    .width_word  (width_word),
    .height_word (height_word),
    .pix_res     (pix_res)
  );

  always_comb begin
    phase_next = phase_eff;
    if (hdr_res.fire) begin
      if (hdr_res.code != ST_HDR_OK) begin
        phase_next = PH_IDLE;
      end else if (hdr_res.empty) begin
        phase_next = PH_DONE;
      end else begin
        phase_next = PH_PIXELS;
      end
    end else if (pix_res.fire && pix_res.last) begin
      phase_next = PH_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (go) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && data_valid) begin
      s1_byte  <= data_byte;
      s1_start <= frame_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (go && (hdr_res.fire || pix_res.fire)) begin
      result_valid <= 1'b1;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  // result register; non-pixel fields read zero where they do not apply
  always_ff @(posedge clk) begin
    if (go && hdr_res.fire) begin
      status       <= hdr_res.code;
      red          <= '0;
      green        <= '0;
      blue         <= '0;
      column       <= '0;
      row          <= '0;
      end_of_image <= (hdr_res.code == ST_HDR_OK) && hdr_res.empty;
      image_width  <= (hdr_res.code == ST_HDR_OK) ? hdr_res.img_w : '0;
      image_height <= (hdr_res.code == ST_HDR_OK) ? hdr_res.img_h : '0;
    end else if (go && pix_res.fire) begin
      status       <= ST_PIXEL;
      red          <= pix_res.red;
      green        <= pix_res.green;
      blue         <= pix_res.blue;
      column       <= pix_res.column;
      row          <= pix_res.row;
      end_of_image <= pix_res.last;
      image_width  <= '0;
      image_height <= '0;
    end
  end

`ifndef SYNTH
  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  a_one_source: assert property (@(posedge clk) disable iff (rst)
    !(hdr_res.fire && pix_res.fire))
    else $error("header and pixel results in the same cycle");

  a_last_pixel_done: assert property (@(posedge clk) disable iff (rst)
    go && pix_res.fire && pix_res.last |=> phase == PH_DONE)
    else $error("last pixel did not end the frame");

  a_size_on_ok_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_HDR_OK |-> image_width == 13'd0 && image_height == 13'd0)
    else $error("image size on a result that is not header ok");
`endif

endmodule
